### rtl/tpba_pkg.sv
package tpba_pkg;

  // Widest pool that the slot index can address.
  localparam int MAX_SLOTS = 128;
  localparam int IDX_W     = 7;

  // Request codes.
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Pool select codes.
  localparam logic SEL_A = 1'b0;
  localparam logic SEL_B = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Input word.
  typedef struct packed {
    logic             opcode;
    logic             pool_sel;
    logic [IDX_W-1:0] slot_index;
  } in_word_t;

  // Result word.
  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] granted_slot;
    logic [6:0]       free_a;
    logic [7:0]       free_b;
  } out_word_t;

  // Request from the top level to one pool.
  typedef struct packed {
    logic             en;
    logic             op;
    logic [IDX_W-1:0] idx;
  } pool_req_t;

  // Answer of one pool for the request it sees this cycle.
  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] slot;
  } pool_resp_t;

endpackage

### rtl/tpba_pool.sv
module tpba_pool import tpba_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  pool_req_t  req,
  output pool_resp_t resp,
  output logic [7:0] free_nxt
);

  localparam int CNT_W = $clog2(SLOTS + 1);

  logic [SLOTS-1:0]     map_r;
  logic [SLOTS-1:0]     map_nxt;
  logic [CNT_W-1:0]     used_r;
  logic [CNT_W-1:0]     used_nxt;
  logic [SLOTS-1:0]     free_vec;
  logic [SLOTS-1:0]     first_free;
  logic [IDX_W-1:0]     first_idx;
  logic [MAX_SLOTS-1:0] map_ext;
  logic [SLOTS-1:0]     rel_mask;
  logic                 full;
  logic                 in_range;
  logic                 occupied;

  // Lowest free slot as a one-hot vector: isolate the lowest set bit.
  assign free_vec   = ~map_r;
  assign first_free = free_vec & (~free_vec + SLOTS'(1));

  // Encode the one-hot vector into a slot number.
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (first_free[i]) begin
        first_idx = first_idx | IDX_W'(i);
      end
    end
  end

  // Allocation checks fullness; release checks range first, then occupancy.
  assign full     = (used_r >= CNT_W'(SLOTS));
  assign in_range = ({1'b0, req.idx} < 8'(SLOTS));
  assign map_ext  = MAX_SLOTS'(map_r);
  assign occupied = map_ext[req.idx];
  assign rel_mask = SLOTS'({{(MAX_SLOTS-1){1'b0}}, 1'b1} << req.idx);

  // Decide the answer and the next occupancy state.
  always_comb begin
    map_nxt     = map_r;
    used_nxt    = used_r;
    resp.status = ST_OK;
    resp.slot   = '0;
    if (req.op == OP_ALLOC) begin
      if (full) begin
        resp.status = ST_FULL;
      end else begin
        resp.slot = first_idx;
        if (req.en) begin
          map_nxt  = map_r | first_free;
          used_nxt = used_r + CNT_W'(1);
        end
      end
    end else begin
      if (!in_range) begin
        resp.status = ST_RANGE;
      end else if (!occupied) begin
        resp.status = ST_EMPTY;
      end else if (req.en) begin
        map_nxt  = map_r & ~rel_mask;
        used_nxt = used_r - CNT_W'(1);
      end
    end
  end

  assign free_nxt = 8'(SLOTS) - 8'(used_nxt);

  // Occupancy state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r  <= '0;
      used_r <= '0;
    end else begin
      map_r  <= map_nxt;
      used_r <= used_nxt;
    end
  end

endmodule

### rtl/two_pool_bitmap_slot_allocator.sv
// An accepted request moves from the input register to the result register
// once that register is free. Throughput: one request per cycle unless
// out_ready stalls the result register; the find-first-free encoder over
// the selected pool's bitmap and the occupancy update sit between the registers.
// Reset (synchronous, rst_n low): both bitmaps and used counts clear, so all
// slots are free, and both pipeline stages are emptied.
module two_pool_bitmap_slot_allocator import tpba_pkg::*; #(
  parameter int POOL_A_SLOTS = 64,
  parameter int POOL_B_SLOTS = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic       in_v_r;
  in_word_t   in_r;
  logic       out_v_r;
  out_word_t  out_r;
  out_word_t  out_nxt;
  logic       advance;
  pool_req_t  req_a;
  pool_req_t  req_b;
  pool_resp_t resp_a;
  pool_resp_t resp_b;
  pool_resp_t resp_sel;
  logic [7:0] free_a_nxt;
  logic [7:0] free_b_nxt;

  // The held word moves to the result register when that register is free.
  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  // Route the held word to the selected pool.
  assign req_a.en  = advance && (in_r.pool_sel == SEL_A);
  assign req_a.op  = in_r.opcode;
  assign req_a.idx = in_r.slot_index;
  assign req_b.en  = advance && (in_r.pool_sel == SEL_B);
  assign req_b.op  = in_r.opcode;
  assign req_b.idx = in_r.slot_index;

  tpba_pool #(.SLOTS(POOL_A_SLOTS)) u_pool_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req_a),
    .resp     (resp_a),
    .free_nxt (free_a_nxt)
  );

  tpba_pool #(.SLOTS(POOL_B_SLOTS)) u_pool_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req_b),
    .resp     (resp_b),
    .free_nxt (free_b_nxt)
  );

  // Assemble the result word; free counts are masked to the field widths.
  assign resp_sel             = (in_r.pool_sel == SEL_B) ? resp_b : resp_a;
  assign out_nxt.status       = resp_sel.status;
  assign out_nxt.granted_slot = resp_sel.slot;
  assign out_nxt.free_a       = free_a_nxt[6:0];
  assign out_nxt.free_b       = free_b_nxt;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_word;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

  // A failed request never reports a granted slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status != ST_OK) |-> out_word.granted_slot == '0)
    else $error("granted slot nonzero on a failed request");

  // Free counts never exceed the pool sizes.
  assert property (@(posedge clk) disable iff (!rst_n)
    (free_a_nxt <= 8'(POOL_A_SLOTS)) && (free_b_nxt <= 8'(POOL_B_SLOTS)))
    else $error("free count above pool size");

  // A word that moves on always shows up as a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("result lost after advance");

  // Only one pool is updated by a request.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(req_a.en && req_b.en))
    else $error("both pools enabled at once");

endmodule
